>>> rtl/core/bsrq_pkg.sv
// ============================================================================
// bsrq_pkg - shared types and constants for the bounded set with rank query
// Holds the sizes, operation codes, controller states and the command and
// status bundles between controller and datapath.
// ============================================================================
package bsrq_pkg;

    localparam int CAPACITY    = 256;
    localparam int VALUE_WIDTH = 32;
    localparam int ADDR_WIDTH  = $clog2(CAPACITY);
    localparam int COUNT_WIDTH = $clog2(CAPACITY + 1);
    localparam int MID_WIDTH   = COUNT_WIDTH + 1;

    // Port field widths
    localparam int FUNC_WIDTH      = 2;
    localparam int IN_VALUE_WIDTH  = 32;
    localparam int RANK_WIDTH      = 8;
    localparam int OUT_VALUE_WIDTH = 32;
    localparam int OUT_COUNT_WIDTH = 9;
    localparam int S_TDATA_WIDTH   = IN_VALUE_WIDTH + RANK_WIDTH;
    localparam int M_FIELDS_WIDTH  = OUT_VALUE_WIDTH + OUT_COUNT_WIDTH;
    localparam int M_TDATA_WIDTH   = ((M_FIELDS_WIDTH + 7) / 8) * 8;
    localparam int M_PAD_WIDTH     = M_TDATA_WIDTH - M_FIELDS_WIDTH;
    localparam int WIDE_WIDTH      = (COUNT_WIDTH > RANK_WIDTH) ? COUNT_WIDTH : RANK_WIDTH;

    typedef enum logic [FUNC_WIDTH-1:0] {
        FUNC_INSERT   = 2'd0,
        FUNC_ERASE    = 2'd1,
        FUNC_CONTAINS = 2'd2,
        FUNC_GET      = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_SEARCH_CMP,
        ST_SHIFT,
        ST_SHIFT_WR,
        ST_GET_RD,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic load_in;
        logic search_init;
        logic search_rd;
        logic search_cmp;
        logic decide;
        logic get_rd;
        logic shift_init;
        logic shift_rd;
        logic shift_wr;
        logic finish;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic search_active;
        logic modify;
        logic shift_more;
        logic out_free;
    } status_t;

endpackage

>>> rtl/core/bsrq_datapath.sv
// ============================================================================
// bsrq_datapath - sorted entry store, search bounds, shift pointer, result
// Keeps the entries ascending in a one-write, one-read memory and carries
// out the search, shift and lookup steps that the controller commands.
// ============================================================================
module bsrq_datapath (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  bsrq_pkg::cmd_t                         cmd,
    output bsrq_pkg::status_t                      status,
    input  logic [bsrq_pkg::FUNC_WIDTH-1:0]        in_func,
    input  logic [bsrq_pkg::IN_VALUE_WIDTH-1:0]    in_item_value,
    input  logic [bsrq_pkg::RANK_WIDTH-1:0]        in_rank_index,
    input  logic                                   m_tready,
    output logic                                   m_tvalid,
    output logic                                   m_ok,
    output logic [bsrq_pkg::OUT_VALUE_WIDTH-1:0]   m_result_value,
    output logic [bsrq_pkg::OUT_COUNT_WIDTH-1:0]   m_item_count
);
    import bsrq_pkg::*;

    logic [VALUE_WIDTH-1:0] mem [CAPACITY];

    func_t                   op_reg;
    logic [VALUE_WIDTH-1:0]  val_reg;
    logic [RANK_WIDTH-1:0]   rank_reg;
    logic [COUNT_WIDTH-1:0]  count_reg, count_next;
    logic [COUNT_WIDTH-1:0]  lo_reg, lo_next;
    logic [COUNT_WIDTH-1:0]  hi_reg, hi_next;
    logic                    hit_reg, hit_next;
    logic [COUNT_WIDTH-1:0]  ptr_reg, ptr_next;
    logic                    ok_reg;
    logic [VALUE_WIDTH-1:0]  rd_data_reg;

    logic                    m_valid_reg;
    logic                    m_ok_reg;
    logic [OUT_VALUE_WIDTH-1:0] m_value_reg;
    logic [OUT_COUNT_WIDTH-1:0] m_count_reg;

    logic [MID_WIDTH-1:0]    sum_w;
    logic [ADDR_WIDTH-1:0]   mid_w;
    logic                    full_w;
    logic                    rank_ok_w;
    logic                    ok_w;
    logic                    rd_en;
    logic [ADDR_WIDTH-1:0]   rd_addr;
    logic                    wr_en;
    logic [ADDR_WIDTH-1:0]   wr_addr;
    logic [VALUE_WIDTH-1:0]  wr_data;
    logic [COUNT_WIDTH-1:0]  ptr_dn_w;
    logic [COUNT_WIDTH-1:0]  ptr_up_w;

    assign sum_w     = MID_WIDTH'(lo_reg) + MID_WIDTH'(hi_reg);
    assign mid_w     = sum_w[ADDR_WIDTH:1];
    assign full_w    = (count_reg == COUNT_WIDTH'(CAPACITY));
    assign rank_ok_w = (WIDE_WIDTH'(rank_reg) < WIDE_WIDTH'(count_reg));
    assign ptr_dn_w  = ptr_reg - COUNT_WIDTH'(1);
    assign ptr_up_w  = ptr_reg + COUNT_WIDTH'(1);

    always_comb begin
        case (op_reg)
            FUNC_INSERT:   ok_w = !hit_reg && !full_w;
            FUNC_ERASE:    ok_w = hit_reg;
            FUNC_CONTAINS: ok_w = hit_reg;
            FUNC_GET:      ok_w = rank_ok_w;
            default:       ok_w = 1'b0;
        endcase
    end

    assign status.search_active = (lo_reg < hi_reg);
    assign status.modify        = (op_reg == FUNC_INSERT && !hit_reg && !full_w)
                               || (op_reg == FUNC_ERASE && hit_reg);
    assign status.shift_more    = (op_reg == FUNC_INSERT) ? (ptr_reg > lo_reg)
                                                          : (ptr_up_w < count_reg);
    assign status.out_free      = !m_valid_reg || m_tready;

    // Memory port selection
    always_comb begin
        rd_en   = cmd.search_rd || cmd.shift_rd || cmd.get_rd;
        rd_addr = ADDR_WIDTH'(rank_reg);
        if (cmd.search_rd) begin
            rd_addr = mid_w;
        end else if (cmd.shift_rd) begin
            rd_addr = (op_reg == FUNC_INSERT) ? ptr_dn_w[ADDR_WIDTH-1:0]
                                              : ptr_up_w[ADDR_WIDTH-1:0];
        end
        wr_en   = cmd.shift_wr || (cmd.finish && op_reg == FUNC_INSERT);
        wr_addr = cmd.shift_wr ? ptr_reg[ADDR_WIDTH-1:0] : lo_reg[ADDR_WIDTH-1:0];
        wr_data = cmd.shift_wr ? rd_data_reg : val_reg;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Search bounds, shift pointer and count
    always_comb begin
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        hit_next   = hit_reg;
        ptr_next   = ptr_reg;
        count_next = count_reg;
        if (cmd.search_init) begin
            lo_next  = '0;
            hi_next  = count_reg;
            hit_next = 1'b0;
        end else if (cmd.search_cmp) begin
            if (rd_data_reg < val_reg) begin
                lo_next = COUNT_WIDTH'(mid_w) + COUNT_WIDTH'(1);
            end else begin
                hi_next  = COUNT_WIDTH'(mid_w);
                hit_next = (rd_data_reg == val_reg);
            end
        end
        if (cmd.shift_init) begin
            ptr_next = (op_reg == FUNC_INSERT) ? count_reg : lo_reg;
        end else if (cmd.shift_wr) begin
            ptr_next = (op_reg == FUNC_INSERT) ? ptr_dn_w : ptr_up_w;
        end
        if (cmd.finish) begin
            count_next = (op_reg == FUNC_INSERT) ? count_reg + COUNT_WIDTH'(1)
                                                 : count_reg - COUNT_WIDTH'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (cmd.load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        hit_reg <= hit_next;
        ptr_reg <= ptr_next;
        if (cmd.load_in) begin
            op_reg   <= func_t'(in_func);
            val_reg  <= VALUE_WIDTH'(in_item_value);
            rank_reg <= in_rank_index;
        end
        if (cmd.decide) begin
            ok_reg <= ok_w;
        end
        if (cmd.load_out) begin
            m_ok_reg    <= ok_reg;
            m_value_reg <= (op_reg == FUNC_GET && ok_reg) ? OUT_VALUE_WIDTH'(rd_data_reg)
                                                          : '0;
            m_count_reg <= OUT_COUNT_WIDTH'(count_reg);
        end
    end

    assign m_tvalid       = m_valid_reg;
    assign m_ok           = m_ok_reg;
    assign m_result_value = m_value_reg;
    assign m_item_count   = m_count_reg;

endmodule

>>> rtl/core/bsrq_ctrl.sv
// ============================================================================
// bsrq_ctrl - operation sequencer
// Steps the datapath through search, shift and lookup for one transaction.
// ============================================================================
module bsrq_ctrl (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic [bsrq_pkg::FUNC_WIDTH-1:0] s_func,
    output logic                            s_tready,
    input  bsrq_pkg::status_t               status,
    output bsrq_pkg::cmd_t                  cmd
);
    import bsrq_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    if (func_t'(s_func) == FUNC_GET) begin
                        state_next = ST_GET_RD;
                    end else begin
                        cmd.search_init = 1'b1;
                        state_next      = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH: begin
                if (status.search_active) begin
                    cmd.search_rd = 1'b1;
                    state_next    = ST_SEARCH_CMP;
                end else begin
                    cmd.decide = 1'b1;
                    if (status.modify) begin
                        cmd.shift_init = 1'b1;
                        state_next     = ST_SHIFT;
                    end else begin
                        state_next = ST_RESP;
                    end
                end
            end
            ST_SEARCH_CMP: begin
                cmd.search_cmp = 1'b1;
                state_next     = ST_SEARCH;
            end
            ST_SHIFT: begin
                if (status.shift_more) begin
                    cmd.shift_rd = 1'b1;
                    state_next   = ST_SHIFT_WR;
                end else begin
                    cmd.finish = 1'b1;
                    state_next = ST_RESP;
                end
            end
            ST_SHIFT_WR: begin
                cmd.shift_wr = 1'b1;
                state_next   = ST_SHIFT;
            end
            ST_GET_RD: begin
                cmd.get_rd = 1'b1;
                cmd.decide = 1'b1;
                state_next = ST_RESP;
            end
            ST_RESP: begin
                if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/core/bounded_set_with_rank_query_top.sv
// ============================================================================
// bounded_set_with_rank_query_top - bounded sorted set with rank lookup
// Stream in one operation per transaction, stream out one result for each.
// ============================================================================
// The block holds up to 256 distinct 32-bit values, kept ascending in a
// single-port-read, single-port-write memory. Each input transaction carries
// an operation in s_tuser: insert, erase, contains or get by rank. Every
// transaction returns exactly one result with a success flag, the value at
// the requested rank (successful get only, zero otherwise) and the count
// after the operation. One transaction is worked at a time, and the next is
// taken once the result has been loaded into the output register. Reads are
// registered: get does one read; contains and a failed insert or erase take
// at most ceil(log2(count+1)) steps of binary search, each a read and a
// compare; a successful insert or erase then moves each entry beyond the
// position one place, a read and a write each, and updates the count, an
// insert also writing the new value. The worst case is erasing the smallest
// of 256 entries, plus any wait for the output register to drain. The store
// needs no clearing after reset: only entries below the count are ever used.
// ============================================================================
module bounded_set_with_rank_query_top (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // Input channel
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [bsrq_pkg::S_TDATA_WIDTH-1:0]    s_tdata,   // [31:0] item_value, [39:32] rank_index
    input  logic [bsrq_pkg::FUNC_WIDTH-1:0]       s_tuser,   // [1:0] func
    // Result channel
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [bsrq_pkg::M_TDATA_WIDTH-1:0]    m_tdata,   // [31:0] result_value, [40:32] item_count
    output logic                                  m_tuser    // [0] ok
);
    import bsrq_pkg::*;

    cmd_t    cmd;
    status_t status;

    logic [OUT_VALUE_WIDTH-1:0] result_value;
    logic [OUT_COUNT_WIDTH-1:0] item_count;

    // Sequence each transaction through search, shift and response
    bsrq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_func   (s_tuser),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Hold the sorted store and the result register
    bsrq_datapath u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .in_func        (s_tuser),
        .in_item_value  (s_tdata[IN_VALUE_WIDTH-1:0]),
        .in_rank_index  (s_tdata[S_TDATA_WIDTH-1:IN_VALUE_WIDTH]),
        .m_tready       (m_tready),
        .m_tvalid       (m_tvalid),
        .m_ok           (m_tuser),
        .m_result_value (result_value),
        .m_item_count   (item_count)
    );

    // Pack result fields, low field first, zero pad to whole bytes
    assign m_tdata = {{M_PAD_WIDTH{1'b0}}, item_count, result_value};

endmodule
